// ----- design/assert_macros.svh -----
// Assertion macros for the design files.
// Each macro takes a label, a clock, a reset (active low) and the checked terms.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- design/efd_pkg.sv -----
// Package for the converter frame deframer: constants, frame type, reorder table.
// Used by every module of the block.
`timescale 1ns / 1ps
package efd_pkg;
    localparam int CHANNELS     = 8;
    localparam int SAMPLE_W     = 24;
    localparam int FRAME_BYTES  = 28;
    localparam int HEADER_BYTES = 4;
    localparam int DEF_SLOTS    = 8;
    localparam int FIFO_DEPTH   = 2;
    localparam int POS_W        = 5;
    localparam int CH_W         = 3;

    typedef logic [SAMPLE_W-1:0] t_sample;

    // one complete frame, samples already in output order
    typedef struct packed {
        logic [CHANNELS-1:0][SAMPLE_W-1:0] samples;
        logic [2:0]                        slot;
        logic                              done;
    } t_frame;

    // channel that goes to a given output position
    function automatic logic [CH_W-1:0] reorder(input logic [CH_W-1:0] j);
        logic [CH_W-1:0] ch;
        unique case (j)
            3'd0: ch = 3'd1;
            3'd1: ch = 3'd2;
            3'd2: ch = 3'd7;
            3'd3: ch = 3'd3;
            3'd4: ch = 3'd4;
            3'd5: ch = 3'd5;
            3'd6: ch = 3'd6;
            3'd7: ch = 3'd0;
            default: ch = 3'd0;
        endcase
        return ch;
    endfunction
endpackage

// ----- design/efd_front.sv -----
// Front end: tracks the byte position, assembles samples into the channel store
// and pushes a reordered frame into the queue at the last byte. Uses efd_pkg.
`timescale 1ns / 1ps
module efd_front import efd_pkg::*; #(
    parameter int SLOTS = DEF_SLOTS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_rx_byte,
    input  logic       i_frame_start,
    output logic       o_push,
    output t_frame     o_frame,
    input  logic       i_full
);
    localparam int SW = (SLOTS > 2) ? $clog2(SLOTS) : 1;

    logic [POS_W-1:0] r_pos, n_pos;
    logic [1:0]       r_phase, n_phase;
    logic [CH_W-1:0]  r_ch, n_ch;
    logic [15:0]      r_partial, n_partial;
    logic [CHANNELS-1:0][SAMPLE_W-1:0] r_store;
    logic [SW-1:0]    r_slot, n_slot;

    logic    accept, in_frame, in_data, is_last, slot_wrap;
    t_sample full_sample;

    assign o_ready   = !((r_pos == POS_W'(FRAME_BYTES - 1)) && i_full);
    assign accept    = i_valid && o_ready;
    assign in_frame  = (r_pos != '0) && (r_pos < POS_W'(FRAME_BYTES));
    assign in_data   = in_frame && (r_pos >= POS_W'(HEADER_BYTES));
    assign is_last   = !i_frame_start && (r_pos == POS_W'(FRAME_BYTES - 1));
    assign slot_wrap = (r_slot == SW'(SLOTS - 1));
    assign full_sample = {r_partial, i_rx_byte};
    assign o_push    = accept && is_last;

    always_comb begin
        n_pos     = r_pos;
        n_phase   = r_phase;
        n_ch      = r_ch;
        n_partial = r_partial;
        n_slot    = r_slot;
        if (accept) begin
            if (i_frame_start) begin
                n_pos   = POS_W'(1);
                n_phase = 2'd0;
                n_ch    = '0;
            end else if (!in_frame || is_last) begin
                n_pos = '0;
            end else begin
                n_pos = r_pos + POS_W'(1);
            end
            if (!i_frame_start && in_data) begin
                unique case (r_phase)
                    2'd0: begin
                        n_partial = {8'd0, i_rx_byte};
                        n_phase   = 2'd1;
                    end
                    2'd1: begin
                        n_partial = {r_partial[7:0], i_rx_byte};
                        n_phase   = 2'd2;
                    end
                    default: begin
                        n_phase = 2'd0;
                        n_ch    = r_ch + CH_W'(1);
                    end
                endcase
            end
            if (is_last) begin
                n_slot = slot_wrap ? '0 : r_slot + SW'(1);
            end
        end
    end

    // snapshot of the store, the channel finishing this cycle taken from the bypass
    always_comb begin
        for (int j = 0; j < CHANNELS; j++) begin
            logic [CH_W-1:0] ch;
            ch = reorder(CH_W'(j));
            o_frame.samples[j] = (ch == r_ch) ? full_sample : r_store[ch];
        end
        o_frame.slot = 3'(r_slot);
        o_frame.done = slot_wrap;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_phase   <= 2'd0;
            r_ch      <= '0;
            r_partial <= '0;
            r_slot    <= '0;
        end else begin
            r_pos     <= n_pos;
            r_phase   <= n_phase;
            r_ch      <= n_ch;
            r_partial <= n_partial;
            r_slot    <= n_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !i_frame_start && in_data && (r_phase == 2'd2)) begin
            r_store[r_ch] <= full_sample;
        end
    end
endmodule

// ----- design/efd_fifo.sv -----
// Short frame queue between front and back end.
// Uses the frame type from efd_pkg.
`timescale 1ns / 1ps
module efd_fifo import efd_pkg::*; #(
    parameter int DEPTH = FIFO_DEPTH
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_frame i_frame,
    output logic   o_full,
    output logic   o_valid,
    output t_frame o_frame,
    input  logic   i_pop
);
    localparam int AW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_frame        r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_frame = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            r_cnt <= r_cnt + CW'(do_push) - CW'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_frame;
        end
    end
endmodule

// ----- design/efd_back.sv -----
// Back end: walks the eight samples of the head frame into the output register.
// Uses efd_pkg.
`timescale 1ns / 1ps
module efd_back import efd_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  t_frame              i_q_frame,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic signed [23:0]  o_sample,
    output logic [2:0]          o_out_position,
    output logic [2:0]          o_block_slot,
    output logic                o_block_done,
    output logic                o_last
);
    logic [CH_W-1:0] r_idx;
    logic            r_valid;
    t_sample         r_sample;
    logic [2:0]      r_pos, r_slot;
    logic            r_done, r_last;
    logic            load;

    assign load  = i_q_valid && (!r_valid || i_ready);
    assign o_pop = load && (r_idx == CH_W'(CHANNELS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx   <= r_idx + CH_W'(1);
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_sample <= i_q_frame.samples[r_idx];
            r_pos    <= r_idx;
            r_slot   <= i_q_frame.slot;
            r_done   <= i_q_frame.done;
            r_last   <= (r_idx == CH_W'(CHANNELS - 1));
        end
    end

    assign o_valid        = r_valid;
    assign o_sample       = r_sample;
    assign o_out_position = r_pos;
    assign o_block_slot   = r_slot;
    assign o_block_done   = r_done;
    assign o_last         = r_last;
endmodule

// ----- design/ecg_adc_frame_deframer.sv -----
// Converter frame deframer: 28-byte frames in, eight reordered samples out.
// Input: one byte per cycle; stalls only while byte 27 is due and the two-frame
// queue is full. Frames pass through the queue to the output register, which
// drains at one per cycle while i_ready is high. Reset (synchronous, active
// low) idles the byte tracker, empties the queue and zeroes the slot counter.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ecg_adc_frame_deframer import efd_pkg::*; #(
    parameter int SLOTS = DEF_SLOTS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_rx_byte,
    input  logic               i_frame_start,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [23:0] o_sample,
    output logic [2:0]         o_out_position,
    output logic [2:0]         o_block_slot,
    output logic               o_block_done,
    output logic               o_last
);
    logic   push, q_full, q_valid, pop;
    t_frame push_frame, head_frame;
    logic       out_step;
    logic [2:0] pos_inc;

    efd_front #(.SLOTS(SLOTS)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_rx_byte     (i_rx_byte),
        .i_frame_start (i_frame_start),
        .o_push        (push),
        .o_frame       (push_frame),
        .i_full        (q_full)
    );

    efd_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_frame (push_frame),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_frame (head_frame),
        .i_pop   (pop)
    );

    efd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_frame      (head_frame),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_sample       (o_sample),
        .o_out_position (o_out_position),
        .o_block_slot   (o_block_slot),
        .o_block_done   (o_block_done),
        .o_last         (o_last)
    );

    assign out_step = o_valid && i_ready && !o_last;
    assign pos_inc  = o_out_position + 3'd1;

    // positions within a frame come out in sequence
    `ASSERT_NEXT(a_pos_seq, i_clk, i_rst_n, out_step, !o_valid || o_out_position == $past(pos_inc))
    // a wrap is only flagged on the top slot
    `ASSERT_IMPL(a_done_slot, i_clk, i_rst_n, o_valid && o_block_done, o_block_slot == 3'(SLOTS - 1))
    // input only stalls when the queue cannot take a frame
    `ASSERT_IMPL(a_stall_full, i_clk, i_rst_n, !o_ready, q_full)
    // a frame is never pushed into a full queue
    `ASSERT_IMPL(a_no_overflow, i_clk, i_rst_n, push, !q_full)
endmodule
